[rtl/lfsp_pkg.sv]
// lfsp_pkg: shared constants for the linked free-list slot pool
// operation and status codes, field widths and default pool depth
// no dependencies

package lfsp_pkg;

	localparam int POOL_DEPTH_DEF = 32;
	localparam int MAX_RESULTS    = 32;

	localparam int OP_W     = 2;
	localparam int SLOT_W   = 5;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FREE  = 2'd1;
	localparam op_t OP_LIST  = 2'd2;

	localparam status_t ST_OK          = 2'd0;
	localparam status_t ST_POOL_EMPTY  = 2'd1;
	localparam status_t ST_NOT_ACTIVE  = 2'd2;
	localparam status_t ST_LIST_EMPTY  = 2'd3;

endpackage

[rtl/lfsp_ram.sv]
// lfsp_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module lfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/lifo_free_list_slot_pool_core.sv]
// lifo_free_list_slot_pool_core: slot pool on a lifo free list and an active list
// depends on lfsp_pkg and lfsp_ram (link table and slot value memories)

// A pool of POOL_DEPTH slots sits on two singly linked lists held in a link
// memory; slot values sit in a second memory. Allocate pops the free-list
// head onto the active list and stores the value. Free walks the active list
// from its head through the link memory one slot at a time, then unlinks the
// slot and pushes it onto the free list. List reads link and value together,
// up to 32 results with last on the final one. One item is in work at a time;
// in_ready is high only between items, and the next item is taken while a
// result waits in the output register. The link memory comes out of reset
// ready to use: a valid bit per entry stands in for its initial chaining, so
// no clearing pass is needed.
module lifo_free_list_slot_pool_core #(
	parameter int POOL_DEPTH = lfsp_pkg::POOL_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lfsp_pkg::OP_W-1:0]      operation,
	input  logic [lfsp_pkg::SLOT_W-1:0]    slot_number,
	input  logic [lfsp_pkg::VALUE_W-1:0]   watch_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lfsp_pkg::STATUS_W-1:0]  status,
	output logic [lfsp_pkg::SLOT_W-1:0]    result_slot,
	output logic [lfsp_pkg::VALUE_W-1:0]   result_value,
	output logic                           last
);

	localparam int AW       = $clog2(POOL_DEPTH);
	localparam int LW       = $clog2(POOL_DEPTH + 1);
	localparam int CW       = (LW > lfsp_pkg::SLOT_W) ? LW : lfsp_pkg::SLOT_W;
	localparam int LIST_MAX = (POOL_DEPTH < lfsp_pkg::MAX_RESULTS) ? POOL_DEPTH
	                                                              : lfsp_pkg::MAX_RESULTS;
	localparam int KW       = $clog2(LIST_MAX);

	localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

	typedef logic [LW-1:0] link_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_ALLOC_UPD,
		S_FREE_CHK,
		S_FREE_STEP,
		S_FREE_UNLINK,
		S_FREE_PUSH,
		S_LIST_RD,
		S_LIST_OUT,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic [lfsp_pkg::SLOT_W-1:0]     num_q;
	logic [lfsp_pkg::VALUE_W-1:0]    val_q;
	link_t                           active_head_q;
	link_t                           free_head_q;
	link_t                           cur_q;
	link_t                           prev_q;
	link_t                           steps_q;
	logic [KW-1:0]                   k_q;
	lfsp_pkg::status_t               res_status_q;
	logic [lfsp_pkg::SLOT_W-1:0]     res_slot_q;
	logic [POOL_DEPTH-1:0]           link_valid_q;
	logic                            lv_q;
	logic [AW-1:0]                   raddr_q;

	logic                            out_valid_q;
	lfsp_pkg::status_t               status_q;
	logic [lfsp_pkg::SLOT_W-1:0]     result_slot_q;
	logic [lfsp_pkg::VALUE_W-1:0]    result_value_q;
	logic                            last_q;

	// memory ports
	logic                            link_we;
	logic [AW-1:0]                   link_waddr;
	link_t                           link_wdata;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	link_t                           link_rdata;
	logic                            val_we;
	logic [AW-1:0]                   val_waddr;
	logic [lfsp_pkg::VALUE_W-1:0]    val_wdata;
	logic [lfsp_pkg::VALUE_W-1:0]    val_rdata;

	// derived control
	link_t                           link_data;
	logic                            out_free;
	logic                            cur_null;
	logic                            cur_match;
	logic                            free_null;
	logic                            list_final;

	lfsp_ram #(
		.WIDTH (LW),
		.DEPTH (POOL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	lfsp_ram #(
		.WIDTH (lfsp_pkg::VALUE_W),
		.DEPTH (POOL_DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// never-written link entries read as their reset chaining, slot i to i+1
	assign link_data  = lv_q ? link_rdata : (LW'(raddr_q) + LW'(1));

	assign out_free   = !out_valid_q || out_ready;
	assign cur_null   = (cur_q >= NULL_LINK);
	assign cur_match  = (CW'(cur_q) == CW'(num_q));
	assign free_null  = (free_head_q >= NULL_LINK);
	assign list_final = (link_data >= NULL_LINK) || (k_q == KW'(LIST_MAX - 1));

	// memory read and write requests per sequencer step
	always_comb begin
		link_we    = 1'b0;
		link_waddr = cur_q[AW-1:0];
		link_wdata = link_data;
		val_we     = 1'b0;
		val_waddr  = cur_q[AW-1:0];
		val_wdata  = '0;
		rd_en      = 1'b0;
		rd_addr    = cur_q[AW-1:0];
		unique case (state_q)
			S_ALLOC: begin
				rd_en   = !free_null;
				rd_addr = free_head_q[AW-1:0];
			end
			S_ALLOC_UPD: begin
				link_we    = 1'b1;
				link_waddr = free_head_q[AW-1:0];
				link_wdata = active_head_q;
				val_we     = 1'b1;
				val_waddr  = free_head_q[AW-1:0];
				val_wdata  = val_q;
			end
			S_FREE_CHK: begin
				rd_en = !cur_null && (steps_q != NULL_LINK);
			end
			S_FREE_UNLINK: begin
				link_we    = (prev_q < NULL_LINK);
				link_waddr = prev_q[AW-1:0];
				link_wdata = link_data;
				val_we     = 1'b1;
			end
			S_FREE_PUSH: begin
				link_we    = 1'b1;
				link_wdata = free_head_q;
			end
			S_LIST_RD: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, list heads and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			num_q          <= '0;
			val_q          <= '0;
			active_head_q  <= NULL_LINK;
			free_head_q    <= '0;
			cur_q          <= NULL_LINK;
			prev_q         <= NULL_LINK;
			steps_q        <= '0;
			k_q            <= '0;
			res_status_q   <= lfsp_pkg::ST_OK;
			res_slot_q     <= '0;
			link_valid_q   <= '0;
			lv_q           <= 1'b0;
			raddr_q        <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= lfsp_pkg::ST_OK;
			result_slot_q  <= '0;
			result_value_q <= '0;
			last_q         <= 1'b0;
		end else begin
			// output transfer frees the register
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// capture the validity of the link entry being read
			if (rd_en) begin
				lv_q    <= link_valid_q[rd_addr];
				raddr_q <= rd_addr;
			end
			if (link_we) begin
				link_valid_q[link_waddr] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						num_q   <= slot_number;
						val_q   <= watch_value;
						cur_q   <= active_head_q;
						prev_q  <= NULL_LINK;
						steps_q <= '0;
						k_q     <= '0;
						unique case (operation)
							lfsp_pkg::OP_ALLOC: state_q <= S_ALLOC;
							lfsp_pkg::OP_FREE:  state_q <= S_FREE_CHK;
							lfsp_pkg::OP_LIST: begin
								if (active_head_q >= NULL_LINK) begin
									res_status_q <= lfsp_pkg::ST_LIST_EMPTY;
									res_slot_q   <= '0;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_LIST_RD;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ALLOC: begin
					if (free_null) begin
						res_status_q <= lfsp_pkg::ST_POOL_EMPTY;
						res_slot_q   <= '0;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_ALLOC_UPD;
					end
				end
				S_ALLOC_UPD: begin
					free_head_q   <= link_data;
					active_head_q <= free_head_q;
					res_status_q  <= lfsp_pkg::ST_OK;
					res_slot_q    <= lfsp_pkg::SLOT_W'(free_head_q);
					state_q       <= S_EMIT;
				end
				S_FREE_CHK: begin
					if (cur_null || steps_q == NULL_LINK) begin
						res_status_q <= lfsp_pkg::ST_NOT_ACTIVE;
						res_slot_q   <= num_q;
						state_q      <= S_EMIT;
					end else if (cur_match) begin
						state_q <= S_FREE_UNLINK;
					end else begin
						state_q <= S_FREE_STEP;
					end
				end
				S_FREE_STEP: begin
					prev_q  <= cur_q;
					cur_q   <= link_data;
					steps_q <= steps_q + LW'(1);
					state_q <= S_FREE_CHK;
				end
				S_FREE_UNLINK: begin
					if (prev_q >= NULL_LINK) begin
						active_head_q <= link_data;
					end
					state_q <= S_FREE_PUSH;
				end
				S_FREE_PUSH: begin
					free_head_q  <= cur_q;
					res_status_q <= lfsp_pkg::ST_OK;
					res_slot_q   <= lfsp_pkg::SLOT_W'(cur_q);
					state_q      <= S_EMIT;
				end
				S_LIST_RD: begin
					state_q <= S_LIST_OUT;
				end
				S_LIST_OUT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						status_q       <= lfsp_pkg::ST_OK;
						result_slot_q  <= lfsp_pkg::SLOT_W'(cur_q);
						result_value_q <= val_rdata;
						last_q         <= list_final;
						if (list_final) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= link_data;
							k_q     <= k_q + KW'(1);
							state_q <= S_LIST_RD;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						status_q       <= res_status_q;
						result_slot_q  <= res_slot_q;
						result_value_q <= '0;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_slot  = result_slot_q;
	assign result_value = result_value_q;
	assign last         = last_q;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for lifo_free_list_slot_pool_core
// directed table, then phased random allocate/free/list traffic with random stalls
// depends on lfsp_pkg and the rtl of lifo_free_list_slot_pool_core

module testbench;
	import lfsp_pkg::*;

	localparam int POOL_DEPTH     = POOL_DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 124;
	localparam int PHASE_ITEMS    = 50;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 2 * POOL_DEPTH + 20;
	localparam int N_DIRECTED     = 23;

	localparam op_t        OP_UNDEF  = 2'd3;
	localparam logic [5:0] NULL_LINK = 6'(POOL_DEPTH);

	typedef struct packed {
		status_t      status;
		logic [4:0]   slot;
		logic [63:0]  value;
		logic         last;
	} slot_result_t;

	typedef struct packed {
		op_t          op;
		logic [4:0]   slot;
		logic [63:0]  value;
		logic [5:0]   reps;
		logic         has_exp;
		status_t      exp_status;
		logic [4:0]   exp_slot;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	op_t                 operation;
	logic [SLOT_W-1:0]   slot_number;
	logic [VALUE_W-1:0]  watch_value;
	logic                out_valid;
	logic                out_ready;
	status_t             status;
	logic [SLOT_W-1:0]   result_slot;
	logic [VALUE_W-1:0]  result_value;
	logic                last;

	// predicted pool state
	logic [5:0]   pool_link [POOL_DEPTH];
	logic [63:0]  pool_value [POOL_DEPTH];
	logic [5:0]   pool_active_head;
	logic [5:0]   pool_free_head;

	slot_result_t step_results [$];
	slot_result_t due_results [$];
	slot_result_t head_result;
	int           mismatches;
	int           idle_cycles;

	// directed stimulus; expected result typed in where it is obvious
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_LIST,  5'd0,  64'd0,                   6'd1,  1'b1, ST_LIST_EMPTY, 5'd0},
		'{OP_FREE,  5'd0,  64'd0,                   6'd1,  1'b1, ST_NOT_ACTIVE, 5'd0},
		'{OP_FREE,  5'd31, 64'hffff_ffff_ffff_ffff, 6'd1,  1'b1, ST_NOT_ACTIVE, 5'd31},
		'{OP_UNDEF, 5'd31, 64'hffff_ffff_ffff_ffff, 6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_ALLOC, 5'd0,  64'hffff_ffff_ffff_ffff, 6'd1,  1'b1, ST_OK,         5'd0},
		'{OP_ALLOC, 5'd31, 64'd0,                   6'd1,  1'b1, ST_OK,         5'd1},
		'{OP_ALLOC, 5'd0,  64'h8000_0000_0000_0001, 6'd1,  1'b1, ST_OK,         5'd2},
		'{OP_LIST,  5'd0,  64'd0,                   6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_FREE,  5'd0,  64'd0,                   6'd1,  1'b1, ST_OK,         5'd0},
		'{OP_FREE,  5'd0,  64'd0,                   6'd1,  1'b1, ST_NOT_ACTIVE, 5'd0},
		'{OP_FREE,  5'd2,  64'd0,                   6'd1,  1'b1, ST_OK,         5'd2},
		'{OP_ALLOC, 5'd0,  64'h5555_5555_5555_5555, 6'd1,  1'b1, ST_OK,         5'd2},
		'{OP_ALLOC, 5'd0,  64'h0123_4567_89ab_cdef, 6'd30, 1'b0, ST_OK,         5'd0},
		'{OP_ALLOC, 5'd0,  64'hffff_ffff_ffff_ffff, 6'd1,  1'b1, ST_POOL_EMPTY, 5'd0},
		'{OP_LIST,  5'd0,  64'd0,                   6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_FREE,  5'd1,  64'd0,                   6'd1,  1'b1, ST_OK,         5'd1},
		'{OP_FREE,  5'd17, 64'd0,                   6'd1,  1'b1, ST_OK,         5'd17},
		'{OP_ALLOC, 5'd0,  64'haaaa_0000_ffff_5555, 6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_UNDEF, 5'd0,  64'd0,                   6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_LIST,  5'd0,  64'd0,                   6'd1,  1'b0, ST_OK,         5'd0},
		'{OP_FREE,  5'd31, 64'd0,                   6'd1,  1'b1, ST_OK,         5'd31},
		'{OP_FREE,  5'd1,  64'd0,                   6'd1,  1'b1, ST_NOT_ACTIVE, 5'd1},
		'{OP_LIST,  5'd0,  64'd0,                   6'd1,  1'b0, ST_OK,         5'd0}
	};

	lifo_free_list_slot_pool_core #(
		.POOL_DEPTH(POOL_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.slot_number(slot_number),
		.watch_value(watch_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_slot(result_slot),
		.result_value(result_value),
		.last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_draw();
		return $urandom_range(0, 5);
	endfunction

	function automatic void add_result(status_t st, logic [4:0] s, logic [63:0] v, logic l);
		step_results.push_back('{st, s, v, l});
	endfunction

	// pool behaviour: updates the predicted state, fills step_results
	function automatic void pool_step(op_t op, logic [4:0] num, logic [63:0] val);
		logic [5:0] s;
		logic [5:0] prev;
		logic [5:0] cur;
		logic [5:0] nxt;
		int         steps;
		int         k;
		bit         done;
		step_results.delete();
		case (op)
			OP_ALLOC: begin
				s = pool_free_head;
				if (s >= POOL_DEPTH) begin
					add_result(ST_POOL_EMPTY, 5'd0, 64'd0, 1'b1);
				end else begin
					pool_free_head = pool_link[s];
					pool_link[s] = pool_active_head;
					pool_active_head = s;
					pool_value[s] = val;
					add_result(ST_OK, s[4:0], 64'd0, 1'b1);
				end
			end
			OP_FREE: begin
				prev = NULL_LINK;
				cur = pool_active_head;
				steps = 0;
				// walk the active list looking for the slot
				while (cur < POOL_DEPTH && cur != {1'b0, num} && steps < POOL_DEPTH) begin
					prev = cur;
					cur = pool_link[cur];
					steps++;
				end
				if (cur >= POOL_DEPTH || cur != {1'b0, num}) begin
					add_result(ST_NOT_ACTIVE, num, 64'd0, 1'b1);
				end else begin
					if (prev >= POOL_DEPTH)
						pool_active_head = pool_link[cur];
					else
						pool_link[prev] = pool_link[cur];
					pool_value[cur] = 64'd0;
					pool_link[cur] = pool_free_head;
					pool_free_head = cur;
					add_result(ST_OK, cur[4:0], 64'd0, 1'b1);
				end
			end
			OP_LIST: begin
				cur = pool_active_head;
				if (cur >= POOL_DEPTH) begin
					add_result(ST_LIST_EMPTY, 5'd0, 64'd0, 1'b1);
				end else begin
					k = 0;
					done = 1'b0;
					while (!done) begin
						nxt = pool_link[cur];
						done = (nxt >= POOL_DEPTH) || (k + 1 == MAX_RESULTS) ||
						       (k + 1 == POOL_DEPTH);
						add_result(ST_OK, cur[4:0], pool_value[cur], done);
						k++;
						cur = nxt;
					end
				end
			end
			default: begin
				// undefined code: no result, no change
			end
		endcase
	endfunction

	// random member of the active list, or a random number if none is active
	function automatic logic [4:0] pick_active_slot();
		logic [5:0] cur;
		logic [4:0] members [$];
		cur = pool_active_head;
		while (cur < POOL_DEPTH && members.size() < POOL_DEPTH) begin
			members.push_back(cur[4:0]);
			cur = pool_link[cur];
		end
		if (members.size() == 0)
			return 5'($urandom_range(0, 31));
		return members[$urandom_range(0, members.size() - 1)];
	endfunction

	// one input transfer; valid stays high when the next item follows at once
	task automatic send_item(op_t op, logic [4:0] num, logic [63:0] val, logic has_exp,
	                         status_t exp_status, logic [4:0] exp_slot);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		slot_number <= num;
		watch_value <= val;
		do @(posedge clk); while (!in_ready);
		pool_step(op, num, val);
		if (has_exp)
			due_results.push_back('{exp_status, exp_slot, 64'd0, 1'b1});
		else
			foreach (step_results[j]) due_results.push_back(step_results[j]);
	endtask

	// receiver with random stalls
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$error("unexpected result: status %0d, slot %0d, value %h, last %0d",
				       status, result_slot, result_value, last);
				mismatches++;
			end else begin
				head_result = due_results.pop_front();
				if (status !== head_result.status) begin
					$error("status: expected %0d, got %0d", head_result.status, status);
					mismatches++;
				end
				if (result_slot !== head_result.slot) begin
					$error("result_slot: expected %0d, got %0d", head_result.slot, result_slot);
					mismatches++;
				end
				if (result_value !== head_result.value) begin
					$error("result_value: expected %h, got %h", head_result.value, result_value);
					mismatches++;
				end
				if (last !== head_result.last) begin
					$error("last: expected %0d, got %0d", head_result.last, last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// reset, directed table, random traffic, drain
	initial begin
		int         i;
		int         k;
		int         sent;
		int         roll;
		bit         fill_phase;
		op_t        op;
		logic [4:0] num;
		logic [63:0] val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		slot_number = '0;
		watch_value = '0;
		out_ready = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		fill_phase = 1'b0;
		for (i = 0; i < POOL_DEPTH; i++) begin
			pool_link[i] = (i == POOL_DEPTH - 1) ? NULL_LINK : 6'(i + 1);
			pool_value[i] = 64'd0;
		end
		pool_active_head = NULL_LINK;
		pool_free_head = 6'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		for (i = 0; i < N_DIRECTED; i++) begin
			for (k = 0; k < directed_rows[i].reps; k++)
				send_item(directed_rows[i].op, directed_rows[i].slot,
				          directed_rows[i].value + 64'(k), directed_rows[i].has_exp,
				          directed_rows[i].exp_status, directed_rows[i].exp_slot);
		end

		// random part: alternating drain and fill phases
		sent = 0;
		i = 0;
		while (sent < RANDOM_ITEMS) begin
			if (i % PHASE_ITEMS == 0) begin
				fill_phase = 1'((i / PHASE_ITEMS) % 2);
			end
			roll = $urandom_range(0, 99);
			num = 5'($urandom_range(0, 31));
			val = {$urandom, $urandom};
			if (roll < 3) begin
				op = OP_UNDEF;
			end else if (roll < 11) begin
				op = OP_LIST;
			end else if ((roll < 93) == fill_phase) begin
				op = OP_ALLOC;
			end else begin
				op = OP_FREE;
				if ($urandom_range(0, 6) != 0)
					num = pick_active_slot();
			end
			send_item(op, num, val, 1'b0, ST_OK, 5'd0);
			if (op != OP_UNDEF)
				sent++;
			i++;
		end
		in_valid <= 1'b0;

		// wait for outstanding results, then a quiet tail
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
